>>> rtl/base64_encoder_macros.svh
// base64_encoder_macros.svh: assertion macros for the base64 encoder
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef BASE64_ENCODER_MACROS_SVH
`define BASE64_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define B64_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("base64 encoder check failed");

// next-cycle implication
`define B64_ASSERT_NXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("base64 encoder check failed");

`else

`define B64_ASSERT_IMP(label, clk, rst, cond, prop)
`define B64_ASSERT_NXT(label, clk, rst, cond, prop)

`endif

`endif

>>> rtl/b64_pkg.sv
// b64_pkg: shared types, codes and the alphabet lookup of the base64 encoder
// no dependencies
package b64_pkg;

   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] third_byte;
      logic [1:0] nbytes;
      logic       last;
   } group_type;

   localparam logic [1:0] ONE_BYTE    = 2'd1;
   localparam logic [1:0] TWO_BYTES   = 2'd2;
   localparam logic [1:0] THREE_BYTES = 2'd3;

   localparam logic [1:0] COUNT_EMPTY = 2'd0;
   localparam logic [1:0] COUNT_ONE   = 2'd1;
   localparam logic [1:0] COUNT_TWO   = 2'd2;

   localparam logic [1:0] CHAR_IDX_0 = 2'd0;
   localparam logic [1:0] CHAR_IDX_1 = 2'd1;
   localparam logic [1:0] CHAR_IDX_2 = 2'd2;
   localparam logic [1:0] CHAR_IDX_3 = 2'd3;

   localparam logic [6:0] PAD_CHAR     = 7'h3D;
   localparam logic [6:0] PLUS_CHAR    = 7'h2B;
   localparam logic [6:0] SLASH_CHAR   = 7'h2F;
   localparam logic [6:0] UPPER_OFFSET = 7'h41;
   localparam logic [6:0] LOWER_OFFSET = 7'h47;
   localparam logic [6:0] DIGIT_OFFSET = 7'h04;

   function automatic logic [6:0] sextet_char(input logic [5:0] v);
      logic [6:0] ch;
      case (v) inside
         [6'd0:6'd25]:  ch = {1'b0, v} + UPPER_OFFSET;
         [6'd26:6'd51]: ch = {1'b0, v} + LOWER_OFFSET;
         [6'd52:6'd61]: ch = {1'b0, v} - DIGIT_OFFSET;
         6'd62:         ch = PLUS_CHAR;
         default:       ch = SLASH_CHAR;
      endcase
      return ch;
   endfunction

endpackage

>>> rtl/b64_front.sv
// b64_front: gathers input bytes into groups of one to three bytes
// depends on b64_pkg
module b64_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_push,
   output logic               in_full,
   input  logic [7:0]         in_data_byte,
   input  logic               in_message_end,
   output logic               group_push,
   input  logic               group_full,
   output b64_pkg::group_type group_data
);

   logic [15:0] held_ff, held_in;
   logic [1:0]  count_ff, count_in;
   logic        accept;
   logic        closing;

   assign in_full = group_full;
   assign accept  = in_push && !group_full;
   assign closing = in_message_end || (count_ff >= b64_pkg::COUNT_TWO);

   assign group_push = accept && closing;

   always_comb begin
      group_data.last = in_message_end;
      case (count_ff)
         b64_pkg::COUNT_EMPTY: begin
            group_data.first_byte  = in_data_byte;
            group_data.second_byte = 8'h00;
            group_data.third_byte  = 8'h00;
            group_data.nbytes      = b64_pkg::ONE_BYTE;
         end
         b64_pkg::COUNT_ONE: begin
            group_data.first_byte  = held_ff[15:8];
            group_data.second_byte = in_data_byte;
            group_data.third_byte  = 8'h00;
            group_data.nbytes      = b64_pkg::TWO_BYTES;
         end
         default: begin
            group_data.first_byte  = held_ff[15:8];
            group_data.second_byte = held_ff[7:0];
            group_data.third_byte  = in_data_byte;
            group_data.nbytes      = b64_pkg::THREE_BYTES;
         end
      endcase
   end

   always_comb begin
      held_in  = held_ff;
      count_in = count_ff;
      if (accept) begin
         if (closing) begin
            held_in  = 16'h0000;
            count_in = b64_pkg::COUNT_EMPTY;
         end else begin
            if (count_ff == b64_pkg::COUNT_EMPTY) begin
               held_in = {in_data_byte, 8'h00};
            end else begin
               held_in = {held_ff[15:8], in_data_byte};
            end
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 16'h0000;
         count_ff <= b64_pkg::COUNT_EMPTY;
      end else begin
         held_ff  <= held_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/b64_queue.sv
// b64_queue: short group queue between the byte gatherer and the character serializer
// depends on b64_pkg
module b64_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  b64_pkg::group_type push_data,
   input  logic               pop,
   output logic               empty,
   output b64_pkg::group_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64_pkg::group_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/b64_back.sv
// b64_back: turns each queued group into four characters, one per cycle while out_pop is held
// depends on b64_pkg
module b64_back (
   input  logic               clock,
   input  logic               reset,
   output logic               group_pop,
   input  logic               group_empty,
   input  b64_pkg::group_type group_data,
   output logic               out_empty,
   input  logic               out_pop,
   output logic [6:0]         out_char,
   output logic               out_group_end,
   output logic               out_stream_end
);

   b64_pkg::group_type cur_ff, cur_in;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       group_end_ff, group_end_in;
   logic       stream_end_ff, stream_end_in;
   logic       advance;
   logic       finishing;
   logic [5:0] sextet;
   logic       pad;

   assign advance   = busy_ff && (!valid_ff || out_pop);
   assign finishing = advance && (idx_ff == b64_pkg::CHAR_IDX_3);
   assign group_pop = !group_empty && (!busy_ff || finishing);

   always_comb begin
      case (idx_ff)
         b64_pkg::CHAR_IDX_0: begin
            sextet = cur_ff.first_byte[7:2];
            pad    = 1'b0;
         end
         b64_pkg::CHAR_IDX_1: begin
            sextet = {cur_ff.first_byte[1:0], cur_ff.second_byte[7:4]};
            pad    = 1'b0;
         end
         b64_pkg::CHAR_IDX_2: begin
            sextet = {cur_ff.second_byte[3:0], cur_ff.third_byte[7:6]};
            pad    = (cur_ff.nbytes == b64_pkg::ONE_BYTE);
         end
         default: begin
            sextet = cur_ff.third_byte[5:0];
            pad    = (cur_ff.nbytes != b64_pkg::THREE_BYTES);
         end
      endcase
   end

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (group_pop) begin
         cur_in  = group_data;
         busy_in = 1'b1;
         idx_in  = b64_pkg::CHAR_IDX_0;
      end else if (finishing) begin
         busy_in = 1'b0;
      end else if (advance) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_comb begin
      valid_in      = valid_ff;
      char_in       = char_ff;
      group_end_in  = group_end_ff;
      stream_end_in = stream_end_ff;
      if (advance) begin
         valid_in      = 1'b1;
         char_in       = pad ? b64_pkg::PAD_CHAR : b64_pkg::sextet_char(sextet);
         group_end_in  = (idx_ff == b64_pkg::CHAR_IDX_3);
         stream_end_in = (idx_ff == b64_pkg::CHAR_IDX_3) && cur_ff.last;
      end else if (out_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      char_ff       <= char_in;
      group_end_ff  <= group_end_in;
      stream_end_ff <= stream_end_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= b64_pkg::CHAR_IDX_0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign out_empty      = !valid_ff;
   assign out_char       = char_ff;
   assign out_group_end  = group_end_ff;
   assign out_stream_end = stream_end_ff;

endmodule

>>> rtl/base64_encoder.sv
// base64_encoder: top level of a standard-alphabet base64 encoder for a byte stream,
// built from b64_front, b64_queue and b64_back, using b64_pkg and base64_encoder_macros.svh.
// A byte beat is taken whenever the group queue has room; every third byte,
// or a byte flagged as message end, closes a group that is padded with '=' when short.
// Each group leaves as four character beats, one per cycle while rsp_pop is held, from a
// registered output, so the character serializer sets the sustained rate; QUEUE_DEPTH groups
// can wait between the two halves.
`include "base64_encoder_macros.svh"

module base64_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_message_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [6:0] rsp_out_char,
   output logic       rsp_group_end,
   output logic       rsp_stream_end
);

   b64_pkg::group_type push_group;
   b64_pkg::group_type pop_group;
   logic q_push;
   logic q_full;
   logic q_pop;
   logic q_empty;

   b64_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_push        (req_push),
      .in_full        (req_full),
      .in_data_byte   (req_data_byte),
      .in_message_end (req_message_end),
      .group_push     (q_push),
      .group_full     (q_full),
      .group_data     (push_group)
   );

   b64_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .full      (q_full),
      .push_data (push_group),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (pop_group)
   );

   b64_back u_back (
      .clock          (clock),
      .reset          (reset),
      .group_pop      (q_pop),
      .group_empty    (q_empty),
      .group_data     (pop_group),
      .out_empty      (rsp_empty),
      .out_pop        (rsp_pop),
      .out_char       (rsp_out_char),
      .out_group_end  (rsp_group_end),
      .out_stream_end (rsp_stream_end)
   );

   `B64_ASSERT_IMP(a_push_room, clock, reset, q_push, !q_full)
   `B64_ASSERT_IMP(a_pop_data, clock, reset, q_pop, !q_empty)
   `B64_ASSERT_IMP(a_end_on_group, clock, reset, !rsp_empty && rsp_stream_end, rsp_group_end)
   `B64_ASSERT_NXT(a_push_fills, clock, reset, q_push, !q_empty)

endmodule
